// ----- hw/rtl/adjacency_list_graph_store_defines.svh -----
// assertion macros for the graph store
`ifndef ADJACENCY_LIST_GRAPH_STORE_DEFINES_SVH
`define ADJACENCY_LIST_GRAPH_STORE_DEFINES_SVH

// implication checked on every clock edge outside reset
`define ALG_ASSERT_IMP(label, clk, rstn, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rstn) (ante) |-> (cons)) \
        else $error(msg);

// implication whose consequent is checked in the cycle after the antecedent
`define ALG_ASSERT_NEXT(label, clk, rstn, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rstn) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ----- hw/rtl/alg_pkg.sv -----
// ----------------------------------------------------------------------------
// alg_pkg
// types, codes and sizes shared by the graph store modules
// ----------------------------------------------------------------------------
`default_nettype none

package alg_pkg;

    localparam int MAX_VERTICES_DEF   = 128;
    localparam int MAX_EDGE_NODES_DEF = 256;

    localparam logic [2:0] CMD_INS_VERTEX = 3'd0;
    localparam logic [2:0] CMD_INS_EDGE   = 3'd1;
    localparam logic [2:0] CMD_HAS_EDGE   = 3'd2;
    localparam logic [2:0] CMD_DEGREE     = 3'd3;
    localparam logic [2:0] CMD_CLEAR      = 3'd4;

    localparam logic [2:0] ST_OK    = 3'd0;
    localparam logic [2:0] ST_DUP   = 3'd1;
    localparam logic [2:0] ST_FULL  = 3'd2;
    localparam logic [2:0] ST_NOVTX = 3'd3;
    localparam logic [2:0] ST_POOL  = 3'd4;

    typedef struct packed {
        logic [2:0]         command;
        logic [7:0]         label_a;
        logic [7:0]         label_b;
        logic signed [15:0] weight;
        logic               directed;
    } alg_in_t;

    typedef struct packed {
        logic [2:0] status;
        logic [6:0] vertex_index;
        logic       edge_present;
        logic [8:0] degree_count;
        logic [7:0] vertex_total;
        logic [8:0] edge_total;
    } alg_out_t;

    typedef enum logic [3:0] {
        S_IDLE,
        S_SCAN,
        S_DECIDE,
        S_PUSH_A,
        S_PUSH_B,
        S_WALK_RD,
        S_WALK_CHK,
        S_RESULT,
        S_OUT
    } alg_state_t;

    // controller to datapath
    typedef struct packed {
        logic load;        // capture input item
        logic scan_start;  // reset vertex scan
        logic scan_step;   // compare one label
        logic ins_vertex;  // append vertex
        logic push_a;      // push entry into source list
        logic push_b;      // push reverse entry
        logic edge_inc;    // count one edge insert
        logic walk_start;  // load list head
        logic walk_rd;     // issue entry read
        logic walk_adv;    // follow link
        logic clear;       // empty table and pool
        logic set_status;  // latch status
        logic [2:0] status;
        logic set_present;
        logic out_load;    // build result register
    } alg_cmd_t;

    // datapath to controller
    typedef struct packed {
        logic [2:0] command;
        logic       directed;
        logic       scan_done;
        logic       found_a;
        logic       found_b;
        logic       table_full;
        logic       pool_short;
        logic       walk_end;
        logic       hit;
    } alg_sts_t;

endpackage

`default_nettype wire

// ----- hw/rtl/alg_ctrl.sv -----
// ----------------------------------------------------------------------------
// alg_ctrl
// command sequencer for the graph store
// ----------------------------------------------------------------------------
`default_nettype none
`include "adjacency_list_graph_store_defines.svh"

module alg_ctrl (
    input  wire logic              aclk,
    input  wire logic              aresetn,
    input  wire logic              s_valid,
    output logic                   s_ready,
    output logic                   m_valid,
    input  wire logic              m_ready,
    input  wire alg_pkg::alg_sts_t sts,
    output alg_pkg::alg_cmd_t      cmd
);

    alg_pkg::alg_state_t state_reg, state_next;
    logic m_valid_reg, m_valid_next;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= alg_pkg::S_IDLE;
            m_valid_reg <= 1'b0;
        end else begin
            state_reg   <= state_next;
            m_valid_reg <= m_valid_next;
        end
    end

    assign s_ready = (state_reg == alg_pkg::S_IDLE);
    assign m_valid = m_valid_reg;

    always_comb begin
        state_next = state_reg;
        case (state_reg)
            alg_pkg::S_IDLE: begin
                if (s_valid) state_next = alg_pkg::S_SCAN;
            end
            alg_pkg::S_SCAN: begin
                if (sts.command == alg_pkg::CMD_CLEAR
                        || sts.command > alg_pkg::CMD_CLEAR) begin
                    state_next = alg_pkg::S_RESULT;
                end else if (sts.scan_done) begin
                    state_next = alg_pkg::S_DECIDE;
                end
            end
            alg_pkg::S_DECIDE: begin
                state_next = alg_pkg::S_RESULT;
                if (sts.command == alg_pkg::CMD_INS_EDGE) begin
                    if (sts.found_a && sts.found_b && !sts.pool_short) begin
                        state_next = alg_pkg::S_PUSH_A;
                    end
                end else if (sts.command == alg_pkg::CMD_HAS_EDGE) begin
                    if (sts.found_a && sts.found_b) state_next = alg_pkg::S_WALK_RD;
                end else if (sts.command == alg_pkg::CMD_DEGREE) begin
                    if (sts.found_a) state_next = alg_pkg::S_WALK_RD;
                end
            end
            alg_pkg::S_PUSH_A: begin
                state_next = sts.directed ? alg_pkg::S_RESULT : alg_pkg::S_PUSH_B;
            end
            alg_pkg::S_PUSH_B: state_next = alg_pkg::S_RESULT;
            alg_pkg::S_WALK_RD: begin
                state_next = sts.walk_end ? alg_pkg::S_RESULT : alg_pkg::S_WALK_CHK;
            end
            alg_pkg::S_WALK_CHK: begin
                if (sts.command == alg_pkg::CMD_HAS_EDGE && sts.hit) begin
                    state_next = alg_pkg::S_RESULT;
                end else begin
                    state_next = alg_pkg::S_WALK_RD;
                end
            end
            alg_pkg::S_RESULT: state_next = alg_pkg::S_OUT;
            alg_pkg::S_OUT: begin
                if (!m_valid_reg || m_ready) state_next = alg_pkg::S_IDLE;
            end
            default: state_next = alg_pkg::S_IDLE;
        endcase
    end

    always_comb begin
        cmd = '0;
        m_valid_next = m_valid_reg && !m_ready;
        case (state_reg)
            alg_pkg::S_IDLE: begin
                cmd.load       = s_valid;
                cmd.scan_start = s_valid;
            end
            alg_pkg::S_SCAN: begin
                cmd.scan_step = 1'b1;
            end
            alg_pkg::S_DECIDE: begin
                cmd.set_status = 1'b1;
                cmd.status     = alg_pkg::ST_OK;
                if (sts.command == alg_pkg::CMD_INS_VERTEX) begin
                    if (sts.table_full) begin
                        cmd.status = alg_pkg::ST_FULL;
                    end else if (sts.found_a) begin
                        cmd.status = alg_pkg::ST_DUP;
                    end else begin
                        cmd.ins_vertex = 1'b1;
                    end
                end else if (sts.command == alg_pkg::CMD_INS_EDGE) begin
                    if (!sts.found_a || !sts.found_b) begin
                        cmd.status = alg_pkg::ST_NOVTX;
                    end else if (sts.pool_short) begin
                        cmd.status = alg_pkg::ST_POOL;
                    end else begin
                        cmd.edge_inc = 1'b1;
                    end
                end else if (sts.command == alg_pkg::CMD_HAS_EDGE) begin
                    if (!sts.found_a || !sts.found_b) begin
                        cmd.status = alg_pkg::ST_NOVTX;
                    end else begin
                        cmd.walk_start = 1'b1;
                    end
                end else begin
                    if (!sts.found_a) begin
                        cmd.status = alg_pkg::ST_NOVTX;
                    end else begin
                        cmd.walk_start = 1'b1;
                    end
                end
            end
            alg_pkg::S_PUSH_A: cmd.push_a = 1'b1;
            alg_pkg::S_PUSH_B: cmd.push_b = 1'b1;
            alg_pkg::S_WALK_RD: cmd.walk_rd = !sts.walk_end;
            alg_pkg::S_WALK_CHK: begin
                if (sts.command == alg_pkg::CMD_HAS_EDGE && sts.hit) begin
                    cmd.set_present = 1'b1;
                end else begin
                    cmd.walk_adv = 1'b1;
                end
            end
            alg_pkg::S_RESULT: begin
                cmd.clear = (sts.command == alg_pkg::CMD_CLEAR);
            end
            alg_pkg::S_OUT: begin
                if (!m_valid_reg || m_ready) begin
                    cmd.out_load = 1'b1;
                    m_valid_next = 1'b1;
                end
            end
            default: ;
        endcase
    end

    `ALG_ASSERT_IMP(a_ready_idle_only, aclk, aresetn, s_ready, !cmd.out_load, "ready while output loads")
    `ALG_ASSERT_NEXT(a_out_valid, aclk, aresetn, cmd.out_load, m_valid, "result lost")
    `ALG_ASSERT_IMP(a_push_b_undir, aclk, aresetn, state_reg == alg_pkg::S_PUSH_B, !sts.directed, "reverse push on directed edge")

endmodule

`default_nettype wire

// ----- hw/rtl/alg_datapath.sv -----
// ----------------------------------------------------------------------------
// alg_datapath
// vertex table, edge pool, counters and result register
// ----------------------------------------------------------------------------
`default_nettype none
`include "adjacency_list_graph_store_defines.svh"

module alg_datapath #(
    parameter int MAX_VERTICES   = alg_pkg::MAX_VERTICES_DEF,
    parameter int MAX_EDGE_NODES = alg_pkg::MAX_EDGE_NODES_DEF
) (
    input  wire logic              aclk,
    input  wire logic              aresetn,
    input  wire alg_pkg::alg_in_t  s_data,
    input  wire alg_pkg::alg_cmd_t cmd,
    output alg_pkg::alg_sts_t      sts,
    output alg_pkg::alg_out_t      m_data
);

    localparam int VW = $clog2(MAX_VERTICES);
    localparam int VC = $clog2(MAX_VERTICES + 1);
    localparam int EW = $clog2(MAX_EDGE_NODES);
    localparam int EC = $clog2(MAX_EDGE_NODES + 1);
    localparam logic [EC-1:0] LINK_END = EC'(MAX_EDGE_NODES);

    // memories
    logic [7:0]        vlabel_mem [MAX_VERTICES];
    logic [EC-1:0]     vhead_mem  [MAX_VERTICES];
    logic [VW-1:0]     etgt_mem   [MAX_EDGE_NODES];
    logic [15:0]       ewgt_mem   [MAX_EDGE_NODES];
    logic [EC-1:0]     elink_mem  [MAX_EDGE_NODES];

    alg_pkg::alg_in_t  item_reg;
    logic [VC-1:0]     vcount_reg, vcount_next;
    logic [EC-1:0]     pool_reg, pool_next;
    logic [EC-1:0]     ecount_reg, ecount_next;
    logic [VC-1:0]     scan_reg;
    logic              found_a_reg, found_b_reg;
    logic [VW-1:0]     idx_a_reg, idx_b_reg;
    logic [7:0]        lbl_rd_reg;
    logic              lbl_ok_reg;
    logic [VW-1:0]     lbl_idx_reg;
    logic [EC-1:0]     head_rd_reg;
    logic [EC-1:0]     ptr_reg;
    logic [EC-1:0]     steps_reg;
    logic [VW-1:0]     tgt_rd_reg;
    logic [EC-1:0]     link_rd_reg;
    logic [8:0]        degree_reg;
    logic [2:0]        status_reg;
    logic              present_reg;
    logic [VW-1:0]     vidx_reg;
    alg_pkg::alg_out_t out_reg;
    logic [VW-1:0]     head_addr;
    logic [VW-1:0]     ins_idx;
    logic [EW-1:0]     pool_idx;

    assign ins_idx  = vcount_reg[VW-1:0];
    assign pool_idx = pool_reg[EW-1:0];
    // source head ahead of the first push and the walk, reverse head during it
    assign head_addr = cmd.push_a ? idx_b_reg : idx_a_reg;

    always_ff @(posedge aclk) begin
        if (cmd.load) item_reg <= s_data;
    end

    // vertex label memory: one read a cycle during scan
    always_ff @(posedge aclk) begin
        if (cmd.ins_vertex) vlabel_mem[ins_idx] <= item_reg.label_a;
        lbl_rd_reg  <= vlabel_mem[scan_reg[VW-1:0]];
        lbl_idx_reg <= scan_reg[VW-1:0];
    end

    // list head memory, read ahead of push or walk
    always_ff @(posedge aclk) begin
        if (cmd.ins_vertex) begin
            vhead_mem[ins_idx] <= LINK_END;
        end else if (cmd.push_a) begin
            vhead_mem[idx_a_reg] <= pool_reg;
        end else if (cmd.push_b) begin
            vhead_mem[idx_b_reg] <= pool_reg;
        end
        // self-loop: reverse push must see the entry just pushed
        head_rd_reg <= (cmd.push_a && idx_a_reg == idx_b_reg) ? pool_reg
                                                              : vhead_mem[head_addr];
    end

    // edge pool memories
    always_ff @(posedge aclk) begin
        if (cmd.push_a || cmd.push_b) begin
            etgt_mem[pool_idx]  <= cmd.push_a ? idx_b_reg : idx_a_reg;
            ewgt_mem[pool_idx]  <= item_reg.weight;
            elink_mem[pool_idx] <= head_rd_reg;
        end
        tgt_rd_reg  <= etgt_mem[ptr_reg[EW-1:0]];
        link_rd_reg <= elink_mem[ptr_reg[EW-1:0]];
    end

    // vertex scan: one label a cycle, read data registered and used in the cycle after its address
    always_ff @(posedge aclk) begin
        if (cmd.scan_start) begin
            scan_reg    <= '0;
            lbl_ok_reg  <= 1'b0;
            found_a_reg <= 1'b0;
            found_b_reg <= 1'b0;
            idx_a_reg   <= '0;
            idx_b_reg   <= '0;
        end else if (cmd.scan_step) begin
            lbl_ok_reg <= (scan_reg < vcount_reg);
            if (scan_reg < vcount_reg) scan_reg <= scan_reg + 1'b1;
            if (lbl_ok_reg && !found_a_reg && lbl_rd_reg == item_reg.label_a) begin
                found_a_reg <= 1'b1;
                idx_a_reg   <= lbl_idx_reg;
            end
            if (lbl_ok_reg && !found_b_reg && lbl_rd_reg == item_reg.label_b) begin
                found_b_reg <= 1'b1;
                idx_b_reg   <= lbl_idx_reg;
            end
        end
    end

    // list walk
    always_ff @(posedge aclk) begin
        if (cmd.walk_start) begin
            ptr_reg    <= head_rd_reg;
            steps_reg  <= '0;
            degree_reg <= '0;
        end else if (cmd.walk_adv) begin
            ptr_reg    <= link_rd_reg;
            steps_reg  <= steps_reg + 1'b1;
            degree_reg <= degree_reg + 9'd1;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            vcount_reg <= '0;
            pool_reg   <= '0;
            ecount_reg <= '0;
        end else begin
            vcount_reg <= vcount_next;
            pool_reg   <= pool_next;
            ecount_reg <= ecount_next;
        end
    end

    always_comb begin
        vcount_next = vcount_reg;
        pool_next   = pool_reg;
        ecount_next = ecount_reg;
        if (cmd.clear) begin
            vcount_next = '0;
            pool_next   = '0;
            ecount_next = '0;
        end else begin
            if (cmd.ins_vertex) vcount_next = vcount_reg + 1'b1;
            if (cmd.push_a || cmd.push_b) pool_next = pool_reg + 1'b1;
            if (cmd.edge_inc) ecount_next = ecount_reg + 1'b1;
        end
    end

    always_ff @(posedge aclk) begin
        if (cmd.load) begin
            status_reg  <= alg_pkg::ST_OK;
            present_reg <= 1'b0;
            vidx_reg    <= '0;
        end else begin
            if (cmd.set_status) status_reg <= cmd.status;
            if (cmd.set_present) present_reg <= 1'b1;
            if (cmd.ins_vertex) vidx_reg <= ins_idx;
        end
    end

    always_ff @(posedge aclk) begin
        if (cmd.out_load) begin
            out_reg.status       <= status_reg;
            out_reg.vertex_index <= 7'(vidx_reg);
            out_reg.edge_present <= present_reg;
            out_reg.degree_count <= (item_reg.command == alg_pkg::CMD_DEGREE
                                     && status_reg == alg_pkg::ST_OK) ? degree_reg : 9'd0;
            out_reg.vertex_total <= 8'(vcount_reg);
            out_reg.edge_total   <= 9'(ecount_reg);
        end
    end

    assign m_data = out_reg;

    assign sts.command    = item_reg.command;
    assign sts.directed   = item_reg.directed;
    assign sts.scan_done  = (scan_reg >= vcount_reg) && !lbl_ok_reg;
    assign sts.found_a    = found_a_reg;
    assign sts.found_b    = found_b_reg;
    assign sts.table_full = (vcount_reg >= VC'(MAX_VERTICES));
    assign sts.pool_short = item_reg.directed ? (pool_reg >= LINK_END)
                                              : (pool_reg + 1'b1 >= LINK_END);
    assign sts.walk_end   = (ptr_reg >= LINK_END) || (steps_reg >= LINK_END);
    assign sts.hit        = (tgt_rd_reg == idx_b_reg);

    `ALG_ASSERT_IMP(a_pool_bound, aclk, aresetn, 1'b1, pool_reg <= LINK_END, "pool count overflow")
    `ALG_ASSERT_IMP(a_vcount_bound, aclk, aresetn, 1'b1, vcount_reg <= VC'(MAX_VERTICES), "vertex count overflow")
    `ALG_ASSERT_IMP(a_push_room, aclk, aresetn, cmd.push_a || cmd.push_b, pool_reg < LINK_END, "push into full pool")

endmodule

`default_nettype wire

// ----- hw/rtl/adjacency_list_graph_store.sv -----
// sequence: after the input transfer the controller scans the vertex labels and decides;
//   an edge insert then pushes one or two entries and a query walks the source list (up
//   to a hit for has-edge), neither on an error; clear and unused codes skip from scan to result
// throughput: one command at a time, s_ready returns the cycle after the result loads;
//   a result still waiting holds the next command in its output state
// reset: aresetn synchronous active low clears counts and control; memories hold junk
// ----------------------------------------------------------------------------
// adjacency_list_graph_store
// graph store with labeled vertices and linked edge lists in a fixed pool
// ----------------------------------------------------------------------------
`default_nettype none

module adjacency_list_graph_store #(
    parameter int MAX_VERTICES   = alg_pkg::MAX_VERTICES_DEF,
    parameter int MAX_EDGE_NODES = alg_pkg::MAX_EDGE_NODES_DEF
) (
    input  wire logic             aclk,
    input  wire logic             aresetn,
    // command transfer
    input  wire logic             s_valid,
    output logic                  s_ready,
    input  wire alg_pkg::alg_in_t s_data,
    // result transfer
    output logic                  m_valid,
    input  wire logic             m_ready,
    output alg_pkg::alg_out_t     m_data
);

    alg_pkg::alg_cmd_t cmd;   // sequencer commands
    alg_pkg::alg_sts_t sts;   // datapath status

    // controller walks the command through scan, decide, push or walk
    alg_ctrl u_ctrl (
        .aclk    (aclk),
        .aresetn (aresetn),
        .s_valid (s_valid),
        .s_ready (s_ready),
        .m_valid (m_valid),
        .m_ready (m_ready),
        .sts     (sts),
        .cmd     (cmd)
    );

    // datapath owns all storage and the result register
    alg_datapath #(
        .MAX_VERTICES   (MAX_VERTICES),
        .MAX_EDGE_NODES (MAX_EDGE_NODES)
    ) u_dp (
        .aclk    (aclk),
        .aresetn (aresetn),
        .s_data  (s_data),
        .cmd     (cmd),
        .sts     (sts),
        .m_data  (m_data)
    );

endmodule

`default_nettype wire

// ----- bench/adjacency_list_graph_store_tb.sv -----
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// adjacency_list_graph_store_tb
// drives vertex and edge commands through the graph store and checks every
// result against a behavioral model of the vertex table and edge pool
// ----------------------------------------------------------------------------
`default_nettype none

module adjacency_list_graph_store_tb;

    localparam int NV = alg_pkg::MAX_VERTICES_DEF;
    localparam int NE = alg_pkg::MAX_EDGE_NODES_DEF;
    localparam int WATCHDOG_LIMIT = 40000;

    logic              aclk;
    logic              aresetn;
    logic              s_valid;
    logic              s_ready;
    alg_pkg::alg_in_t  s_data;
    logic              m_valid;
    logic              m_ready;
    alg_pkg::alg_out_t m_data;

    adjacency_list_graph_store DUT (
        .aclk(aclk), .aresetn(aresetn),
        .s_valid(s_valid), .s_ready(s_ready), .s_data(s_data),
        .m_valid(m_valid), .m_ready(m_ready), .m_data(m_data)
    );

    // 12 ns clock
    always begin
        aclk = 1'b1; #6;
        aclk = 1'b0; #6;
    end

    // graph model state
    logic [7:0]  gm_labels [NV];
    int          gm_heads  [NV];
    int          gm_targets[NE];
    int          gm_links  [NE];
    int          gm_vcount, gm_pool, gm_ecount;

    alg_pkg::alg_out_t pending_results[$];
    int          error_count = 0;
    int          sent_count = 0;
    int          checked_count = 0;
    int          idle_cycles = 0;
    int          max_degree_seen = 0;
    logic        stall_enable = 1'b1;

    function automatic int find_label(logic [7:0] lbl);
        for (int i = 0; i < gm_vcount; i++)
            if (gm_labels[i] == lbl) return i;
        return NV;
    endfunction

    function automatic void push_edge(int owner, int tgt);
        gm_targets[gm_pool] = tgt;
        gm_links[gm_pool]   = gm_heads[owner];
        gm_heads[owner]     = gm_pool;
        gm_pool++;
    endfunction

    // compute the result one command produces and update the model
    function automatic alg_pkg::alg_out_t graph_apply(alg_pkg::alg_in_t c);
        alg_pkg::alg_out_t r;
        int ia, ib, p, steps;
        r = '0;
        r.status = alg_pkg::ST_OK;
        case (c.command)
            alg_pkg::CMD_INS_VERTEX: begin
                if (gm_vcount >= NV) r.status = alg_pkg::ST_FULL;
                else if (find_label(c.label_a) != NV) r.status = alg_pkg::ST_DUP;
                else begin
                    gm_labels[gm_vcount] = c.label_a;
                    gm_heads[gm_vcount]  = NE;
                    r.vertex_index = gm_vcount[6:0];
                    gm_vcount++;
                end
            end
            alg_pkg::CMD_INS_EDGE: begin
                ia = find_label(c.label_a);
                ib = find_label(c.label_b);
                if (ia == NV || ib == NV) r.status = alg_pkg::ST_NOVTX;
                else if (NE - gm_pool < (c.directed ? 1 : 2)) r.status = alg_pkg::ST_POOL;
                else begin
                    push_edge(ia, ib);
                    if (!c.directed) push_edge(ib, ia);
                    gm_ecount++;
                end
            end
            alg_pkg::CMD_HAS_EDGE, alg_pkg::CMD_DEGREE: begin
                ia = find_label(c.label_a);
                ib = (c.command == alg_pkg::CMD_HAS_EDGE) ? find_label(c.label_b) : 0;
                if (ia == NV || ib == NV) r.status = alg_pkg::ST_NOVTX;
                else begin
                    p = gm_heads[ia];
                    steps = 0;
                    while (p < NE && steps < NE) begin
                        if (c.command == alg_pkg::CMD_HAS_EDGE && gm_targets[p] == ib) begin
                            r.edge_present = 1'b1;
                            break;
                        end
                        r.degree_count++;
                        p = gm_links[p];
                        steps++;
                    end
                    if (c.command == alg_pkg::CMD_HAS_EDGE) r.degree_count = '0;
                    else if (r.degree_count > max_degree_seen)
                        max_degree_seen = r.degree_count;
                end
            end
            alg_pkg::CMD_CLEAR: begin
                gm_vcount = 0;
                gm_pool   = 0;
                gm_ecount = 0;
            end
            default: ;
        endcase
        r.vertex_total = gm_vcount[7:0];
        r.edge_total   = gm_ecount[8:0];
        return r;
    endfunction

    // random gap, mostly short, rarely long
    function automatic int gap_len();
        int k;
        k = $urandom_range(0, 99);
        if (k < 50) return 0;
        if (k < 92) return $urandom_range(1, 3);
        return $urandom_range(10, 60);
    endfunction

    // send one command transfer, prediction made at acceptance
    task automatic send_cmd(alg_pkg::alg_in_t c);
        int g;
        g = stall_enable ? gap_len() : 0;
        // always step past the falling edge that dropped the previous valid
        repeat (g + 1) @(negedge aclk);
        s_data  <= c;
        s_valid <= 1'b1;
        do @(posedge aclk); while (!s_ready);
        pending_results.push_back(graph_apply(c));
        sent_count++;
        @(negedge aclk);
        s_valid <= 1'b0;
    endtask

    task automatic send_fields(logic [2:0] cmd, logic [7:0] la, logic [7:0] lb,
                               logic [15:0] w, logic d);
        alg_pkg::alg_in_t c;
        c.command = cmd; c.label_a = la; c.label_b = lb;
        c.weight = w; c.directed = d;
        send_cmd(c);
    endtask

    task automatic wait_drained();
        while (pending_results.size() != 0) @(negedge aclk);
    endtask

    // result sink with random backpressure
    initial begin
        m_ready = 1'b0;
        forever begin
            @(negedge aclk);
            m_ready <= (stall_enable && $urandom_range(0, 99) < 30) ? 1'b0 : 1'b1;
        end
    end

    // result checker, sampled at the rising edge
    always @(posedge aclk) begin
        alg_pkg::alg_out_t exp_r;
        if (aresetn && m_valid && m_ready) begin
            if (pending_results.size() == 0) begin
                $error("result transfer with nothing expected");
                error_count++;
            end else begin
                exp_r = pending_results.pop_front();
                checked_count++;
                if (m_data.status !== exp_r.status) begin
                    $error("status exp %0d got %0d", exp_r.status, m_data.status);
                    error_count++;
                end
                if (m_data.vertex_index !== exp_r.vertex_index) begin
                    $error("vertex_index exp %0d got %0d",
                           exp_r.vertex_index, m_data.vertex_index);
                    error_count++;
                end
                if (m_data.edge_present !== exp_r.edge_present) begin
                    $error("edge_present exp %0d got %0d",
                           exp_r.edge_present, m_data.edge_present);
                    error_count++;
                end
                if (m_data.degree_count !== exp_r.degree_count) begin
                    $error("degree_count exp %0d got %0d",
                           exp_r.degree_count, m_data.degree_count);
                    error_count++;
                end
                if (m_data.vertex_total !== exp_r.vertex_total) begin
                    $error("vertex_total exp %0d got %0d",
                           exp_r.vertex_total, m_data.vertex_total);
                    error_count++;
                end
                if (m_data.edge_total !== exp_r.edge_total) begin
                    $error("edge_total exp %0d got %0d",
                           exp_r.edge_total, m_data.edge_total);
                    error_count++;
                end
            end
        end
    end

    // watchdog: cycles with no transfer on either side
    always @(posedge aclk) begin
        if ((s_valid && s_ready) || (m_valid && m_ready)) idle_cycles <= 0;
        else idle_cycles <= idle_cycles + 1;
        if (idle_cycles >= WATCHDOG_LIMIT) begin
            $display("watchdog expired, %0d results outstanding", pending_results.size());
            $display("adjacency_list_graph_store_tb: errors");
            $finish;
        end
    end

    // pick a label that is mostly present in the table
    function automatic logic [7:0] pick_label();
        if (gm_vcount > 0 && $urandom_range(0, 99) < 85)
            return gm_labels[$urandom_range(0, gm_vcount - 1)];
        return 8'($urandom_range(0, 255));
    endfunction

    // extremes of the fields, every command and the duplicate and missing-vertex error codes
    task automatic test_directed();
        send_fields(alg_pkg::CMD_DEGREE, 8'h00, 8'h00, 16'h0000, 1'b0);       // empty table
        send_fields(alg_pkg::CMD_INS_VERTEX, 8'h00, 8'h00, 16'h0000, 1'b0);
        send_fields(alg_pkg::CMD_INS_VERTEX, 8'hFF, 8'hFF, 16'hFFFF, 1'b1);
        send_fields(alg_pkg::CMD_INS_VERTEX, 8'h00, 8'h00, 16'h0000, 1'b0);   // duplicate
        send_fields(alg_pkg::CMD_INS_EDGE, 8'h00, 8'hFF, 16'h7FFF, 1'b1);
        send_fields(alg_pkg::CMD_INS_EDGE, 8'hFF, 8'h00, 16'h8000, 1'b0);
        send_fields(alg_pkg::CMD_INS_EDGE, 8'h00, 8'h00, 16'h0001, 1'b0);     // self-loop
        send_fields(alg_pkg::CMD_INS_EDGE, 8'h00, 8'hFF, 16'h1234, 1'b1);     // duplicate edge
        send_fields(alg_pkg::CMD_INS_EDGE, 8'h55, 8'h00, 16'h0000, 1'b1);     // unknown source
        send_fields(alg_pkg::CMD_INS_EDGE, 8'h00, 8'hAA, 16'h0000, 1'b0);     // unknown dest
        send_fields(alg_pkg::CMD_HAS_EDGE, 8'h00, 8'hFF, 16'h0000, 1'b0);
        send_fields(alg_pkg::CMD_HAS_EDGE, 8'hFF, 8'hFF, 16'h0000, 1'b0);
        send_fields(alg_pkg::CMD_HAS_EDGE, 8'h00, 8'h77, 16'h0000, 1'b0);
        send_fields(alg_pkg::CMD_DEGREE, 8'h00, 8'h00, 16'h0000, 1'b0);
        send_fields(alg_pkg::CMD_DEGREE, 8'hFF, 8'h00, 16'h0000, 1'b0);
        send_fields(alg_pkg::CMD_DEGREE, 8'h42, 8'h00, 16'h0000, 1'b0);
        send_fields(3'd5, 8'hFF, 8'hFF, 16'hFFFF, 1'b1);                      // unused codes
        send_fields(3'd6, 8'h00, 8'h00, 16'h0000, 1'b0);
        send_fields(3'd7, 8'h12, 8'h34, 16'h5555, 1'b1);
        send_fields(alg_pkg::CMD_CLEAR, 8'hFF, 8'hFF, 16'hFFFF, 1'b1);
        send_fields(alg_pkg::CMD_DEGREE, 8'h00, 8'h00, 16'h0000, 1'b0);       // gone after clear
    endtask

    // fill the vertex table to the top, then the pool to exhaustion
    task automatic test_capacity();
        send_fields(alg_pkg::CMD_CLEAR, 8'h00, 8'h00, 16'h0000, 1'b0);
        for (int i = 0; i < NV; i++)
            send_fields(alg_pkg::CMD_INS_VERTEX, 8'(i * 2), 8'h00, 16'($urandom), 1'b0);
        send_fields(alg_pkg::CMD_INS_VERTEX, 8'h01, 8'h00, 16'h0000, 1'b0);   // full wins
        send_fields(alg_pkg::CMD_INS_VERTEX, 8'h00, 8'h00, 16'h0000, 1'b0);   // full before dup
        for (int i = 0; i < 127; i++)
            send_fields(alg_pkg::CMD_INS_EDGE, 8'h00, 8'(($urandom_range(0, NV - 1)) * 2),
                        16'($urandom), 1'b0);
        send_fields(alg_pkg::CMD_INS_EDGE, 8'h00, 8'h02, 16'h0000, 1'b1);     // pool at 255
        send_fields(alg_pkg::CMD_INS_EDGE, 8'h00, 8'h02, 16'h0000, 1'b0);     // needs two
        send_fields(alg_pkg::CMD_INS_EDGE, 8'h04, 8'h02, 16'h0000, 1'b1);     // last entry
        send_fields(alg_pkg::CMD_INS_EDGE, 8'h04, 8'h02, 16'h0000, 1'b1);     // pool error
        send_fields(alg_pkg::CMD_DEGREE, 8'h00, 8'h00, 16'h0000, 1'b0);       // long walk
        send_fields(alg_pkg::CMD_HAS_EDGE, 8'h00, 8'h01, 16'h0000, 1'b0);
        send_fields(alg_pkg::CMD_HAS_EDGE, 8'hFE, 8'h00, 16'h0000, 1'b0);
    endtask

    // random traffic: a mix of all commands with occasional clears and unused codes
    task automatic test_random(int n_items);
        alg_pkg::alg_in_t c;
        int k;
        for (int n = 0; n < n_items; n++) begin
            k = $urandom_range(0, 99);
            c.label_a = pick_label();
            c.label_b = pick_label();
            c.weight = 16'($urandom);
            c.directed = 1'($urandom);
            if (k < 2) c.command = alg_pkg::CMD_CLEAR;
            else if (k < 20) begin
                c.command = alg_pkg::CMD_INS_VERTEX;
                c.label_a = 8'($urandom_range(0, 255));
            end
            else if (k < 55) c.command = alg_pkg::CMD_INS_EDGE;
            else if (k < 75) c.command = alg_pkg::CMD_HAS_EDGE;
            else if (k < 95) c.command = alg_pkg::CMD_DEGREE;
            else c.command = 3'($urandom_range(5, 7));
            send_cmd(c);
            if (n == n_items / 2) begin
                // hold off until everything has come back
                wait_drained();
                stall_enable = 1'b0;
            end
            if (n == n_items / 2 + 60) stall_enable = 1'b1;
        end
    endtask

    initial begin
        aresetn = 1'b0;
        s_valid = 1'b0;
        s_data  = '0;
        repeat (12) @(posedge aclk);
        @(negedge aclk);
        aresetn <= 1'b1;
        @(negedge aclk);

        test_directed();
        test_capacity();
        send_fields(alg_pkg::CMD_CLEAR, 8'h00, 8'h00, 16'h0000, 1'b0);
        test_random(810);

        wait_drained();
        repeat (600) @(negedge aclk);
        $display("sent %0d commands, checked %0d results", sent_count, checked_count);
        $display("covered table full, pool exhaustion, longest degree %0d", max_degree_seen);
        if (error_count == 0 && pending_results.size() == 0) begin
            $display("adjacency_list_graph_store_tb: clean");
        end else begin
            $display("adjacency_list_graph_store_tb: errors");
        end
        $finish;
    end

endmodule

`default_nettype wire
